// ----- hw/rtl/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam int REQ_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK  = {ATTR_RESET, SPACE_CODE};

  localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE    = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ_WAIT,
    ST_SCROLL,
    ST_SCROLL_LAST,
    ST_FILL
  } state_t;

endpackage

// ----- hw/rtl/tcw_front.sv -----
// Request intake: accepts requests and decodes them into queue commands.
module tcw_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcw_pkg::REQ_W-1:0]   req_type,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
  input  logic                        q_full,
  input  logic                        init_busy,
  output logic                        push,
  output tcw_pkg::cmd_t               cmd
);

  logic index_ok;

  assign in_ready = !q_full && !init_busy;
  assign push     = in_valid && in_ready;
  assign index_ok = 32'(cell_index) < tcw_pkg::CELL_COUNT;

  always_comb begin
    cmd.ch   = char_code;
    cmd.addr = tcw_pkg::ADDR_W'(cell_index);
    unique case (req_type)
      tcw_pkg::REQ_PUT: begin
        cmd.op = (char_code == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::OP_NEWLINE : tcw_pkg::OP_PUT;
      end
      tcw_pkg::REQ_CLEAR: begin
        cmd.op = tcw_pkg::OP_CLEAR;
      end
      tcw_pkg::REQ_READ: begin
        cmd.op = index_ok ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
      end
      default: begin
        cmd.op = tcw_pkg::OP_NOP;
      end
    endcase
  end

endmodule

// ----- hw/rtl/tcw_queue.sv -----
// Small command queue between request intake and the screen engine.
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t din,
  input  logic          pop,
  output tcw_pkg::cmd_t dout,
  output logic          full,
  output logic          empty
);

  tcw_pkg::cmd_t               slots [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tcw_pkg::QCNT_W-1:0]  count;

  assign full  = count == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tcw_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tcw_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + tcw_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - tcw_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/tcw_back.sv -----
// Screen engine: cell store, cursor, scroll and clear sequencing, result register.
module tcw_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data,
  input  tcw_pkg::cmd_t                 head,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          init_busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row,
  output logic [tcw_pkg::COL_OUT_W-1:0] cursor_column,
  output logic [tcw_pkg::CELL_W-1:0]    cell_data
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];

  tcw_pkg::state_t             state, state_next;
  logic [tcw_pkg::ADDR_W-1:0]  ptr, ptr_next;
  logic [tcw_pkg::ROW_W-1:0]   row, row_next;
  logic [tcw_pkg::COL_W-1:0]   col, col_next;
  logic [tcw_pkg::ADDR_W-1:0]  pos, pos_next;
  logic                        cp_pend, cp_pend_next;
  logic [tcw_pkg::ADDR_W-1:0]  cp_dst, cp_dst_next;
  logic [tcw_pkg::ATTR_W-1:0]  attr;
  logic [tcw_pkg::CELL_W-1:0]  rd_data;

  logic                        mem_we;
  logic [tcw_pkg::ADDR_W-1:0]  mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]  mem_wdata;
  logic [tcw_pkg::ADDR_W-1:0]  mem_raddr;

  logic                        out_free;
  logic                        out_load;
  logic [tcw_pkg::CELL_W-1:0]  out_data_next;
  logic                        last_col;
  logic                        last_row;

  assign out_free  = !out_valid || out_ready;
  assign init_busy = state == tcw_pkg::ST_INIT;
  assign last_col  = col == tcw_pkg::LAST_COL;
  assign last_row  = row == tcw_pkg::LAST_ROW;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    row_next      = row;
    col_next      = col;
    pos_next      = pos;
    cp_pend_next  = 1'b0;
    cp_dst_next   = cp_dst;
    mem_we        = 1'b0;
    mem_waddr     = ptr;
    mem_wdata     = {attr, tcw_pkg::SPACE_CODE};
    mem_raddr     = ptr;
    pop           = 1'b0;
    out_load      = 1'b0;
    out_data_next = '0;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tcw_pkg::RESET_BLANK;
        if (ptr == tcw_pkg::LAST_CELL) begin
          state_next = tcw_pkg::ST_IDLE;
        end else begin
          ptr_next = ptr + tcw_pkg::ADDR_W'(1);
        end
      end
      tcw_pkg::ST_IDLE: begin
        mem_raddr = head.addr;
        if (!q_empty && out_free) begin
          pop = 1'b1;
          unique case (head.op)
            tcw_pkg::OP_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = pos;
              mem_wdata = {attr, head.ch};
              if (!last_col) begin
                col_next = col + tcw_pkg::COL_W'(1);
                pos_next = pos + tcw_pkg::ADDR_W'(1);
                out_load = 1'b1;
              end else begin
                col_next = '0;
                if (!last_row) begin
                  row_next = row + tcw_pkg::ROW_W'(1);
                  pos_next = pos + tcw_pkg::ADDR_W'(1);
                  out_load = 1'b1;
                end else begin
                  pos_next   = tcw_pkg::LAST_ROW_BASE;
                  ptr_next   = tcw_pkg::ROW_STRIDE;
                  state_next = tcw_pkg::ST_SCROLL;
                end
              end
            end
            tcw_pkg::OP_NEWLINE: begin
              col_next = '0;
              if (!last_row) begin
                row_next = row + tcw_pkg::ROW_W'(1);
                pos_next = pos - tcw_pkg::ADDR_W'(col) + tcw_pkg::ROW_STRIDE;
                out_load = 1'b1;
              end else begin
                pos_next   = tcw_pkg::LAST_ROW_BASE;
                ptr_next   = tcw_pkg::ROW_STRIDE;
                state_next = tcw_pkg::ST_SCROLL;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              row_next   = '0;
              col_next   = '0;
              pos_next   = '0;
              ptr_next   = '0;
              state_next = tcw_pkg::ST_FILL;
            end
            tcw_pkg::OP_READ: begin
              state_next = tcw_pkg::ST_READ_WAIT;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      tcw_pkg::ST_READ_WAIT: begin
        out_load      = 1'b1;
        out_data_next = rd_data;
        state_next    = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SCROLL: begin
        // read runs one row ahead; the write lands in the next cycle, one row up
        mem_we       = cp_pend;
        mem_waddr    = cp_dst;
        mem_wdata    = rd_data;
        cp_pend_next = 1'b1;
        cp_dst_next  = ptr - tcw_pkg::ROW_STRIDE;
        if (ptr == tcw_pkg::LAST_CELL) begin
          state_next = tcw_pkg::ST_SCROLL_LAST;
        end else begin
          ptr_next = ptr + tcw_pkg::ADDR_W'(1);
        end
      end
      tcw_pkg::ST_SCROLL_LAST: begin
        mem_we     = 1'b1;
        mem_waddr  = cp_dst;
        mem_wdata  = rd_data;
        ptr_next   = tcw_pkg::LAST_ROW_BASE;
        state_next = tcw_pkg::ST_FILL;
      end
      tcw_pkg::ST_FILL: begin
        mem_we = 1'b1;
        if (ptr == tcw_pkg::LAST_CELL) begin
          out_load   = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end else begin
          ptr_next = ptr + tcw_pkg::ADDR_W'(1);
        end
      end
      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tcw_pkg::ST_INIT;
      ptr     <= '0;
      row     <= '0;
      col     <= '0;
      pos     <= '0;
      cp_pend <= 1'b0;
      attr    <= tcw_pkg::ATTR_RESET;
    end else begin
      state   <= state_next;
      ptr     <= ptr_next;
      row     <= row_next;
      col     <= col_next;
      pos     <= pos_next;
      cp_pend <= cp_pend_next;
      if (cfg_write) begin
        attr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_dst <= cp_dst_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cursor_row    <= tcw_pkg::ROW_OUT_W'(row_next);
      cursor_column <= tcw_pkg::COL_OUT_W'(col_next);
      cell_data     <= out_data_next;
    end
  end

endmodule

// ----- hw/rtl/text_console_writer.sv -----
// Text console writer top level: request intake, command queue and screen engine.
// Holds an 80x25 screen of 16-bit cells (attribute high byte, character low byte)
// in a single-port-write, registered-read memory, and returns one result per
// request carrying the cursor position afterwards and, for a read, the cell.
// After reset a clearing pass writes every cell to 0x0F20, during which
// in_ready stays low. A put, newline or unused request that does not scroll
// then completes in the idle state, and a read passes through READ_WAIT for
// the registered memory read. A clear makes one memory write per cell. A put
// or newline that runs off the last row scrolls: row-up copying through the
// memory port followed by blanking of the bottom row. A two-entry command
// queue lets new requests be taken while a result waits or a long operation
// is running.
module text_console_writer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcw_pkg::REQ_W-1:0]     req_type,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row,
  output logic [tcw_pkg::COL_OUT_W-1:0] cursor_column,
  output logic [tcw_pkg::CELL_W-1:0]    cell_data
);

  tcw_pkg::cmd_t front_cmd;
  tcw_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  logic          init_busy;

  tcw_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .char_code  (char_code),
    .cell_index (cell_index),
    .q_full     (q_full),
    .init_busy  (init_busy),
    .push       (push),
    .cmd        (front_cmd)
  );

  tcw_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_cmd),
    .pop   (pop),
    .dout  (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  tcw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .head          (head_cmd),
    .q_empty       (q_empty),
    .pop           (pop),
    .init_busy     (init_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column),
    .cell_data     (cell_data)
  );

endmodule

// ----- sim/text_console_writer_tb.sv -----
// Self-checking testbench for the text console writer: directed and random requests.
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int INDEX_MAX = (1 << INDEX_W) - 1;
  localparam int STALL_LIMIT = 12000;
  localparam int SETTLE_CYCLES = 2200;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int PHASES = 5;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] column;
    logic [CELL_W-1:0]    data_word;
  } console_result_t;

  class console_scoreboard;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    int unsigned row_pos;
    int unsigned col_pos;
    logic [ATTR_W-1:0] attribute;
    console_result_t expected_results[$];
    int error_count;

    function new();
      attribute = ATTR_RESET;
      row_pos = 0;
      col_pos = 0;
      error_count = 0;
      for (int r = 0; r < ROWS; r++) blank_row(r);
    endfunction

    function void set_attribute(logic [ATTR_W-1:0] value);
      attribute = value;
    endfunction

    function void blank_row(int r);
      for (int c = 0; c < COLUMNS; c++) cells[r * COLUMNS + c] = {attribute, SPACE_CODE};
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch,
                               logic [INDEX_W-1:0] idx);
      logic [CELL_W-1:0] data;
      int unsigned pos;
      data = '0;
      case (req)
        REQ_PUT: begin
          if (ch == NEWLINE_CODE) begin
            row_pos++;
            col_pos = 0;
          end else begin
            pos = row_pos * COLUMNS + col_pos;
            if (pos < CELL_COUNT) cells[pos] = {attribute, ch};
            col_pos++;
            if (col_pos >= COLUMNS) begin
              row_pos++;
              col_pos = 0;
            end
          end
          if (row_pos >= ROWS) begin
            // scroll up one row
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
            blank_row(ROWS - 1);
            row_pos = ROWS - 1;
          end
        end
        REQ_CLEAR: begin
          for (int r = 0; r < ROWS; r++) blank_row(r);
          row_pos = 0;
          col_pos = 0;
        end
        REQ_READ: begin
          if (idx < CELL_COUNT) data = cells[idx];
        end
        default: ;
      endcase
      expected_results.push_back('{ROW_OUT_W'(row_pos), COL_OUT_W'(col_pos), data});
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    task check_result(console_result_t got);
      console_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result row=%0d col=%0d data=%h",
                                  got.row, got.column, got.data_word));
      end else begin
        want = expected_results.pop_front();
        if (got.row !== want.row)
          report_mismatch($sformatf("cursor_row %0d, want %0d", got.row, want.row));
        if (got.column !== want.column)
          report_mismatch($sformatf("cursor_column %0d, want %0d", got.column, want.column));
        if (got.data_word !== want.data_word)
          report_mismatch($sformatf("cell_data %h, want %h", got.data_word, want.data_word));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [ATTR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] req_type = '0;
  logic [CHAR_W-1:0] char_code = '0;
  logic [INDEX_W-1:0] cell_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [COL_OUT_W-1:0] cursor_column;
  logic [CELL_W-1:0] cell_data;

  console_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int stall_cycles = 0;
  bit progress;

  text_console_writer dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .char_code(char_code),
    .cell_index(cell_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cursor_row(cursor_row),
    .cursor_column(cursor_column),
    .cell_data(cell_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      progress = 1'b0;
      if (in_valid && in_ready) begin
        sb.note_request(req_type, char_code, cell_index);
        progress = 1'b1;
      end
      if (out_valid && out_ready) begin
        sb.check_result('{cursor_row, cursor_column, cell_data});
        progress = 1'b1;
      end
      if (progress || !(in_valid || sb.pending() != 0)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress in %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                              input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    char_code <= ch;
    cell_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data <= value;
    sb.set_attribute(value);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] random_text_char();
    logic [CHAR_W-1:0] v;
    if ($urandom_range(9) == 0) begin
      do v = CHAR_W'($urandom_range(255)); while (v == NEWLINE_CODE);
    end else begin
      v = CHAR_W'($urandom_range(126, 32));
    end
    return v;
  endfunction

  function automatic logic [INDEX_W-1:0] random_read_index();
    int r;
    r = $urandom_range(99);
    if (r < 45) return INDEX_W'($urandom_range(CELL_COUNT - 1));
    if (r < 80) return INDEX_W'($urandom_range(CELL_COUNT - 1, (ROWS - 5) * COLUMNS));
    if (r < 90) return INDEX_W'($urandom_range(INDEX_MAX, CELL_COUNT));
    return (r < 95) ? INDEX_W'(0) : INDEX_W'(CELL_COUNT - 1);
  endfunction

  function automatic logic [CHAR_W-1:0] any_char();
    return CHAR_W'($urandom_range(255));
  endfunction

  function automatic logic [INDEX_W-1:0] any_index();
    return INDEX_W'($urandom_range(INDEX_MAX));
  endfunction

  task automatic run_directed();
    send_request(REQ_READ, any_char(), INDEX_W'(0));
    send_request(REQ_READ, any_char(), INDEX_W'(CELL_COUNT - 1));
    send_request(REQ_READ, any_char(), INDEX_W'(CELL_COUNT));
    send_request(REQ_READ, any_char(), INDEX_W'(INDEX_MAX));
    send_request(REQ_UNUSED, 8'hFF, INDEX_W'(INDEX_MAX));
    send_request(REQ_PUT, 8'h00, any_index());
    send_request(REQ_PUT, 8'hFF, any_index());
    send_request(REQ_PUT, 8'h41, any_index());
    send_request(REQ_PUT, NEWLINE_CODE, any_index());
    send_request(REQ_PUT, 8'h7F, any_index());
    send_request(REQ_READ, any_char(), INDEX_W'(0));
    send_request(REQ_READ, any_char(), INDEX_W'(1));
    send_request(REQ_READ, any_char(), INDEX_W'(2));
    send_request(REQ_READ, any_char(), INDEX_W'(COLUMNS));
    send_request(REQ_READ, any_char(), INDEX_W'(COLUMNS + 1));
    send_request(REQ_UNUSED, 8'h00, INDEX_W'(0));
    send_request(REQ_CLEAR, any_char(), any_index());
    send_request(REQ_READ, any_char(), INDEX_W'(1));
    send_request(REQ_READ, any_char(), INDEX_W'(COLUMNS));
  endtask

  task automatic run_random(input int target);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(99);
      if (kind < 58) begin
        // one line of text, sometimes long enough to wrap
        len = ($urandom_range(9) == 0) ? $urandom_range(100, 60) : $urandom_range(20);
        for (int i = 0; i < len; i++) send_request(REQ_PUT, random_text_char(), any_index());
        sent += len;
        if ($urandom_range(99) < 85) begin
          send_request(REQ_PUT, NEWLINE_CODE, any_index());
          sent++;
        end
      end else if (kind < 73) begin
        len = $urandom_range(5, 1);
        for (int i = 0; i < len; i++) send_request(REQ_READ, any_char(), random_read_index());
        sent += len;
      end else if (kind < 79) begin
        len = $urandom_range(25, 5);
        for (int i = 0; i < len; i++) send_request(REQ_PUT, NEWLINE_CODE, any_index());
        sent += len;
      end else if (kind < 84) begin
        send_request(REQ_UNUSED, any_char(), any_index());
        sent++;
      end else if (kind < 86) begin
        send_request(REQ_CLEAR, any_char(), any_index());
        sent++;
      end else begin
        send_request(REQ_W'($urandom_range(3)), any_char(), any_index());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: begin
          write_attribute(8'h00);
          send_idle_pct = 51;
          stall_pct = 0;
        end
        2: begin
          write_attribute(8'hFF);
          send_idle_pct = 0;
          stall_pct = 51;
        end
        3: begin
          write_attribute(ATTR_W'($urandom_range(255)));
          send_idle_pct = 37;
          stall_pct = 37;
        end
        4: begin
          write_attribute(ATTR_W'($urandom_range(255)));
          send_idle_pct = 0;
          stall_pct = 0;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      if (phase == 0) run_directed();
      // blank with the new attribute
      if (phase == 2 || phase == 4) send_request(REQ_CLEAR, any_char(), any_index());
      run_random(ITEMS_PER_PHASE);
    end
    drain_results();
    if (sb.error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
